// ===== src/itoa_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; used by itoa_bcd_cell and signed_int_to_decimal_ascii.

package itoa_pkg;

  // Default width of the input value.
  localparam int VALUE_BITS_DEF = 32;

  // ASCII codes of the characters the block emits.
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  // Decimal digits needed for a magnitude up to 2**(bits-1).
  // 30103 / 100000 approximates log10(2) closely enough for 8..63 bits.
  function automatic int num_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Controls broadcast from the sequencer to every digit cell.
  typedef struct packed {
    logic clear;        // set the digit to zero
    logic dabble;       // add-3 adjust, then shift one binary bit in
    logic shift_digit;  // take the neighbor's digit (move toward the top)
  } cell_ctrl_t;

endpackage

// ===== src/itoa_bcd_cell.sv =====
// One decimal digit cell of the double-dabble chain.
// Depends on itoa_pkg for the cell control struct.

module itoa_bcd_cell (
  input  logic                    clk,
  input  itoa_pkg::cell_ctrl_t    ctrl,
  input  logic                    bit_in,
  input  logic [3:0]              digit_in,
  output logic                    bit_out,
  output logic [3:0]              digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adjusted;

  // Add 3 to digits of 5 or more so the shift carries correctly into the next decade.
  assign adjusted = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out  = adjusted[3];

  // Select the next digit value.
  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adjusted[2:0], bit_in};
    end else if (ctrl.shift_digit) begin
      digit_nxt = digit_in;
    end
  end

  // Digit register; cleared by the sequencer at the start of each item.
  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on itoa_pkg and instantiates a row of itoa_bcd_cell.
//
// Usage:
//   Input: drive in_value and raise start; the value is transferred at the
//   rising edge where start is high and busy is low. busy stays high until
//   the last character has left.
//   Output: one character per out_strobe cycle, most significant first, a
//   leading '-' for negative values, no leading zeros, out_last_char on the
//   final character. The receiver cannot stall; each character is present
//   for exactly one cycle.
//   Timing: after the transfer, the magnitude is shifted bit by bit through
//   the row of BCD cells (the double-dabble loop), then the sign is emitted
//   if negative, then leading zero digits are dropped one per cycle and the
//   remaining digits emitted one per cycle. The next transfer can follow
//   right after the last character.
//   Reset: synchronous active-low rst_n returns the sequencer to idle; no
//   state is carried between items.

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_strobe,
  output logic [7:0]                   out_char_code,
  output logic                         out_last_char
);

  localparam int NUM_DIGITS = itoa_pkg::num_digits(VALUE_BITS);
  localparam int BCW        = $clog2(VALUE_BITS);
  localparam int DCW        = $clog2(NUM_DIGITS + 1);

  itoa_pkg::state_t     state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [BCW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]       dig_cnt_r, dig_cnt_nxt;
  itoa_pkg::cell_ctrl_t ctrl;

  logic [NUM_DIGITS-1:0] carry;
  logic [3:0]            digit [NUM_DIGITS];
  logic [3:0]            top_digit;

  assign top_digit = digit[NUM_DIGITS-1];
  assign carry[0]  = mag_r[VALUE_BITS-1];

  // Row of BCD cells, least significant digit at index 0.
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [3:0] from_lower;
    if (i == 0) begin : g_first
      assign from_lower = 4'd0;
    end else begin : g_rest
      assign from_lower = digit[i-1];
    end
    if (i < NUM_DIGITS - 1) begin : g_link
      itoa_bcd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (carry[i]),
        .digit_in  (from_lower),
        .bit_out   (carry[i+1]),
        .digit_out (digit[i])
      );
    end else begin : g_top
      itoa_bcd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (carry[i]),
        .digit_in  (from_lower),
        .bit_out   (),
        .digit_out (digit[i])
      );
    end
  end

  // Sequencer: next state, datapath controls and result outputs.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    ctrl          = '0;
    out_strobe    = 1'b0;
    out_char_code = itoa_pkg::CH_ZERO + {4'd0, top_digit};
    out_last_char = 1'b0;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (start) begin
          neg_nxt     = in_value[VALUE_BITS-1];
          mag_nxt     = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          bit_cnt_nxt = BCW'(VALUE_BITS - 1);
          ctrl.clear  = 1'b1;
          state_nxt   = itoa_pkg::ST_CONVERT;
        end
      end
      itoa_pkg::ST_CONVERT: begin
        ctrl.dabble = 1'b1;
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        dig_cnt_nxt = DCW'(NUM_DIGITS);
        if (bit_cnt_r == '0) begin
          state_nxt = neg_r ? itoa_pkg::ST_SIGN : itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SIGN: begin
        out_strobe    = 1'b1;
        out_char_code = itoa_pkg::CH_MINUS;
        state_nxt     = itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SKIP: begin
        // Drop leading zeros, but always keep the last digit.
        if (top_digit == 4'd0 && dig_cnt_r != DCW'(1)) begin
          ctrl.shift_digit = 1'b1;
          dig_cnt_nxt      = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        out_strobe       = 1'b1;
        out_last_char    = (dig_cnt_r == DCW'(1));
        ctrl.shift_digit = 1'b1;
        dig_cnt_nxt      = dig_cnt_r - 1'b1;
        if (dig_cnt_r == DCW'(1)) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != itoa_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Magnitude shift register and counters.
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
  end

endmodule
